[hw/rtl/blstk_pkg.sv]
//==============================================================================
// blstk_pkg: shared types and constants for the bounded LIFO stack
// Request and result layouts, action and status codes, controller states
// and the command and status groups between the controller and the datapath.
//==============================================================================
`default_nettype none

package blstk_pkg;

    localparam int DEPTH_DEFAULT      = 128;
    localparam int DATA_WIDTH_DEFAULT = 8;

    localparam logic [2:0] ACT_PUSH   = 3'd0;
    localparam logic [2:0] ACT_POP    = 3'd1;
    localparam logic [2:0] ACT_TOP    = 3'd2;
    localparam logic [2:0] ACT_BOTTOM = 3'd3;
    localparam logic [2:0] ACT_SEARCH = 3'd4;
    localparam logic [2:0] ACT_FLUSH  = 3'd5;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] value;
    } request_t;

    typedef struct packed {
        logic [7:0] data;
        logic       found;
        logic [1:0] status;
        logic [7:0] count;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH
    } state_t;

    typedef struct packed {
        logic accept;
        logic execute;
        logic scan;
    } dp_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/blstk_ctrl.sv]
//==============================================================================
// blstk_ctrl: request sequencer
// Steps each request through execute and, if a search has entries, the scan.
//==============================================================================
`default_nettype none

module blstk_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output blstk_pkg::dp_cmd_t      cmd,
    input  wire blstk_pkg::dp_stat_t stat
);

    blstk_pkg::state_t state_reg;
    blstk_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blstk_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            blstk_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = blstk_pkg::S_EXEC;
                end
            end
            blstk_pkg::S_EXEC:
            begin
                state_next = stat.need_scan ? blstk_pkg::S_SEARCH : blstk_pkg::S_IDLE;
            end
            blstk_pkg::S_SEARCH:
            begin
                if (stat.scan_done)
                begin
                    state_next = blstk_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = blstk_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.accept  = 1'b0;
        cmd.execute = 1'b0;
        cmd.scan    = 1'b0;
        busy        = 1'b1;
        unique case (state_reg)
            blstk_pkg::S_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            blstk_pkg::S_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            blstk_pkg::S_SEARCH:
            begin
                cmd.scan = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/blstk_dp.sv]
//==============================================================================
// blstk_dp: stack datapath
// Entry memory, entry count, scan pointer and the result register.
//==============================================================================
`default_nettype none

module blstk_dp #(
    parameter int DEPTH      = blstk_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = blstk_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire blstk_pkg::request_t   request,
    input  wire blstk_pkg::dp_cmd_t    cmd,
    output blstk_pkg::dp_stat_t        stat,
    output logic                       done,
    output blstk_pkg::result_t         result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]         rd_addr;

    blstk_pkg::request_t   req_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [AW-1:0]         idx_reg;
    logic                  done_reg;
    logic                  done_next;
    blstk_pkg::result_t    result_reg;
    blstk_pkg::result_t    result_next;

    logic [DATA_WIDTH-1:0] val_w;
    logic                  is_full;
    logic                  is_empty;
    logic                  wr_en;
    logic                  hit;
    logic                  last;

    assign val_w    = DATA_WIDTH'(req_reg.value);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign wr_en    = cmd.execute && (req_reg.action == blstk_pkg::ACT_PUSH) && !is_full;
    assign hit      = (rd_data_reg == val_w);
    assign last     = ((CW'(idx_reg) + CW'(1)) == count_reg);

    assign stat.need_scan = (req_reg.action == blstk_pkg::ACT_SEARCH) && !is_empty;
    assign stat.scan_done = hit || last;

    // Pick the entry that the next cycle needs: top/bottom on accept, then scan
    always_comb
    begin
        rd_addr = '0;
        if (cmd.accept && (request.action == blstk_pkg::ACT_TOP))
        begin
            rd_addr = AW'(count_reg - CW'(1));
        end
        else if (cmd.scan)
        begin
            rd_addr = idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(count_reg)] <= val_w;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = '0;
        if (cmd.execute)
        begin
            done_next = !stat.need_scan;
            unique case (req_reg.action) inside
                blstk_pkg::ACT_PUSH:
                begin
                    if (is_full)
                    begin
                        result_next.status = blstk_pkg::STS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                blstk_pkg::ACT_POP:
                begin
                    if (is_empty)
                    begin
                        result_next.status = blstk_pkg::STS_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                blstk_pkg::ACT_TOP, blstk_pkg::ACT_BOTTOM:
                begin
                    if (is_empty)
                    begin
                        result_next.status = blstk_pkg::STS_EMPTY;
                    end
                    else
                    begin
                        result_next.data = 8'(rd_data_reg);
                    end
                end
                blstk_pkg::ACT_FLUSH:
                begin
                    count_next = '0;
                end
                default:
                begin
                    result_next.status = blstk_pkg::STS_OK;
                end
            endcase
        end
        else if (cmd.scan)
        begin
            done_next         = stat.scan_done;
            result_next.found = hit;
        end
        result_next.count = 8'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= request;
        end
        // Restart the scan at the bottom entry, then advance one per cycle
        if (cmd.execute)
        begin
            idx_reg <= '0;
        end
        else if (cmd.scan)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (done_next)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[hw/rtl/bounded_lifo_stack_with_search_unit.sv]
//==============================================================================
// bounded_lifo_stack_with_search_unit: bounded LIFO stack with value search
// Holds up to DEPTH entries; pushes, pops, reads top or bottom, searches
// for a value and flushes, one request at a time.
//==============================================================================
// Usage:
//   Drive request and raise start; the request is taken at a rising edge
//   where start is high and busy is low. busy stays high while it executes.
//   Each request gives exactly one result on result, marked by a one-cycle
//   done strobe; there is no hold-off on the result side, so capture it
//   in that cycle.
//   Push, pop, read top, read bottom, flush, unused codes and a search of
//   an empty stack pass from accept through the execute state to a
//   registered done. A search walks the entry memory one entry a cycle
//   from the bottom through its single read port and stops at the first
//   match or at the top entry, after 1 to count entries (at most DEPTH).
//   A new request may be accepted in the cycle done is shown.
//   Reset (rst_n low, asynchronous) empties the stack and drops any
//   request in progress; the entry memory is not cleared.
//==============================================================================
`default_nettype none

module bounded_lifo_stack_with_search_unit #(
    parameter int DEPTH      = blstk_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = blstk_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire blstk_pkg::request_t request,
    output logic                     done,
    output blstk_pkg::result_t       result
);

    blstk_pkg::dp_cmd_t  cmd;
    blstk_pkg::dp_stat_t stat;

    blstk_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    blstk_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

[hw/rtl/blstk_checker.sv]
//==============================================================================
// blstk_checker: port-level checks for the bounded LIFO stack
// Watches the request and result ports over time.
//==============================================================================
`default_nettype none

module blstk_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire blstk_pkg::request_t request,
    input wire logic                done,
    input wire blstk_pkg::result_t  result
);

    // An accepted request keeps the unit busy for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // A result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_empty_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == blstk_pkg::STS_EMPTY)) |->
            (result.data == 8'd0 && !result.found))
        else $error("empty status with data or found set");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |-> (result.status == blstk_pkg::STS_OK))
        else $error("found set with error status");

endmodule

bind bounded_lifo_stack_with_search_unit blstk_checker u_blstk_checker (.*);

`default_nettype wire

[dv/tb.sv]
//------------------------------------------------------------------------------
// tb: self-checking testbench for bounded_lifo_stack_with_search_unit
// Drives push, pop, read top, read bottom, search, flush and the unused action
// codes through the start/busy handshake. A scoreboard keeps its own copy of
// the stack, predicts each result and compares it field by field with what
// the block returns on its done strobe.
//------------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STACK_DEPTH  = blstk_pkg::DEPTH_DEFAULT;
    localparam int          RANDOM_ITEMS = 1400;
    localparam int          CALM_TAIL    = 200;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          DRAIN_CYCLES = STACK_DEPTH + 32;
    localparam int          MAX_PRINTS   = 100;
    localparam logic [2:0]  ACT_UNUSED6  = 3'd6;
    localparam logic [2:0]  ACT_UNUSED7  = 3'd7;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED,
        MODE_SEARCH
    } traffic_mode_t;

    class stack_scoreboard;
        logic [7:0]          entries [STACK_DEPTH];
        int unsigned         held;
        blstk_pkg::result_t  expected_q [$];
        int unsigned         mismatches;

        function new();
            held = 0;
            mismatches = 0;
            foreach (entries[i])
                entries[i] = '0;
        endfunction

        // Advance the stack copy by one request and return its result.
        function blstk_pkg::result_t apply_request(blstk_pkg::request_t req);
            blstk_pkg::result_t res;
            res = '0;
            res.status = blstk_pkg::STS_OK;
            case (req.action)
                blstk_pkg::ACT_PUSH:
                begin
                    if (held >= STACK_DEPTH)
                        res.status = blstk_pkg::STS_FULL;
                    else
                    begin
                        entries[held] = req.value;
                        held++;
                    end
                end
                blstk_pkg::ACT_POP:
                begin
                    if (held == 0)
                        res.status = blstk_pkg::STS_EMPTY;
                    else
                        held--;
                end
                blstk_pkg::ACT_TOP:
                begin
                    if (held == 0)
                        res.status = blstk_pkg::STS_EMPTY;
                    else
                        res.data = entries[held - 1];
                end
                blstk_pkg::ACT_BOTTOM:
                begin
                    if (held == 0)
                        res.status = blstk_pkg::STS_EMPTY;
                    else
                        res.data = entries[0];
                end
                blstk_pkg::ACT_SEARCH:
                begin
                    for (int i = 0; i < held; i++)
                        if (entries[i] == req.value)
                            res.found = 1'b1;
                end
                blstk_pkg::ACT_FLUSH:
                    held = 0;
                default:
                    ;
            endcase
            res.count = held[7:0];
            return res;
        endfunction

        function void note_request(blstk_pkg::request_t req);
            expected_q.push_back(apply_request(req));
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_result(blstk_pkg::result_t got);
            blstk_pkg::result_t exp;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            exp = expected_q.pop_front();
            if (got.data !== exp.data)
                report($sformatf("data got %0h want %0h", got.data, exp.data));
            if (got.found !== exp.found)
                report($sformatf("found got %0b want %0b", got.found, exp.found));
            if (got.status !== exp.status)
                report($sformatf("status got %0d want %0d", got.status, exp.status));
            if (got.count !== exp.count)
                report($sformatf("count got %0d want %0d", got.count, exp.count));
        endtask

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        function logic [7:0] entry_at(int unsigned idx);
            return entries[idx];
        endfunction
    endclass

    logic                clk;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    blstk_pkg::request_t request = '0;
    logic                busy;
    logic                done;
    blstk_pkg::result_t  result;

    stack_scoreboard sb = new();
    int unsigned     cycle_count = 0;

    bounded_lifo_stack_with_search_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Hold the request until the block takes it; leave start high.
    task automatic issue(input logic [2:0] action, input logic [7:0] value);
        blstk_pkg::request_t req;
        req.action = action;
        req.value  = value;
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(req);
    endtask

    task automatic maybe_pause(input bit enabled);
        if (enabled && $urandom_range(0, 99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic wait_settled();
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic logic [2:0] pick_action(traffic_mode_t mode);
        int p;
        p = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                return (p < 88) ? blstk_pkg::ACT_PUSH :
                       (p < 94) ? blstk_pkg::ACT_SEARCH :
                       (p < 97) ? blstk_pkg::ACT_TOP : blstk_pkg::ACT_BOTTOM;
            MODE_DRAIN:
                return (p < 80) ? blstk_pkg::ACT_POP :
                       (p < 88) ? blstk_pkg::ACT_SEARCH :
                       (p < 93) ? blstk_pkg::ACT_TOP :
                       (p < 97) ? blstk_pkg::ACT_BOTTOM : blstk_pkg::ACT_PUSH;
            MODE_SEARCH:
                return (p < 25) ? blstk_pkg::ACT_PUSH :
                       (p < 35) ? blstk_pkg::ACT_POP :
                       (p < 90) ? blstk_pkg::ACT_SEARCH :
                       (p < 95) ? blstk_pkg::ACT_TOP : blstk_pkg::ACT_BOTTOM;
            default:
                return (p < 35) ? blstk_pkg::ACT_PUSH :
                       (p < 60) ? blstk_pkg::ACT_POP :
                       (p < 70) ? blstk_pkg::ACT_TOP :
                       (p < 78) ? blstk_pkg::ACT_BOTTOM :
                       (p < 93) ? blstk_pkg::ACT_SEARCH :
                       (p < 97) ? blstk_pkg::ACT_FLUSH :
                       (p < 99) ? ACT_UNUSED6 : ACT_UNUSED7;
        endcase
    endfunction

    // Half the time, with entries held, look for one at a random depth.
    function automatic logic [7:0] pick_search_value();
        if (sb.held > 0 && $urandom_range(0, 1) == 1)
            return sb.entry_at($urandom_range(0, sb.held - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        traffic_mode_t mode;
        int            seg_len;
        int            sent;
        bit            idle_on;
        bit            first_seg;
        logic [2:0]    action;
        logic [7:0]    value;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty stack cases, unused codes, value extremes, flush with stale bits.
        issue(blstk_pkg::ACT_POP, 8'h00);       maybe_pause(1'b1);
        issue(blstk_pkg::ACT_TOP, 8'hFF);       maybe_pause(1'b1);
        issue(blstk_pkg::ACT_BOTTOM, 8'h00);
        issue(blstk_pkg::ACT_SEARCH, 8'h00);    maybe_pause(1'b1);
        issue(ACT_UNUSED6, 8'hA5);
        issue(ACT_UNUSED7, 8'h5A);
        issue(blstk_pkg::ACT_PUSH, 8'h00);      maybe_pause(1'b1);
        issue(blstk_pkg::ACT_PUSH, 8'hFF);
        issue(blstk_pkg::ACT_TOP, 8'h00);
        issue(blstk_pkg::ACT_BOTTOM, 8'h00);    maybe_pause(1'b1);
        issue(blstk_pkg::ACT_SEARCH, 8'hFF);
        issue(blstk_pkg::ACT_SEARCH, 8'h00);
        issue(blstk_pkg::ACT_SEARCH, 8'h80);    maybe_pause(1'b1);
        issue(blstk_pkg::ACT_PUSH, 8'h80);
        issue(blstk_pkg::ACT_POP, 8'h00);
        issue(blstk_pkg::ACT_TOP, 8'h00);       maybe_pause(1'b1);
        issue(blstk_pkg::ACT_FLUSH, 8'h00);
        issue(blstk_pkg::ACT_TOP, 8'h00);
        issue(blstk_pkg::ACT_SEARCH, 8'hFF);    maybe_pause(1'b1);
        issue(blstk_pkg::ACT_PUSH, 8'h7F);
        issue(blstk_pkg::ACT_BOTTOM, 8'h00);
        issue(blstk_pkg::ACT_POP, 8'h00);
        issue(blstk_pkg::ACT_POP, 8'h00);

        // Let the pipeline run dry before random traffic.
        start <= 1'b0;
        wait_settled();
        @(posedge clk);

        sent = 0;
        first_seg = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            // The first segment is mostly pushes to fill the stack.
            if (first_seg)
            begin
                mode = MODE_FILL;
                seg_len = 150;
                first_seg = 1'b0;
            end
            else
            begin
                mode = traffic_mode_t'($urandom_range(0, 3));
                seg_len = $urandom_range(20, 150);
            end
            idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++)
            begin
                action = pick_action(mode);
                value = (action == blstk_pkg::ACT_SEARCH) ? pick_search_value()
                                                          : 8'($urandom_range(0, 255));
                issue(action, value);
                sent++;
                maybe_pause(idle_on && sent < RANDOM_ITEMS - CALM_TAIL);
            end
        end

        start <= 1'b0;
        wait_settled();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
hw/rtl/blstk_pkg.sv
hw/rtl/blstk_ctrl.sv
hw/rtl/blstk_dp.sv
hw/rtl/bounded_lifo_stack_with_search_unit.sv
hw/rtl/blstk_checker.sv
dv/tb.sv
